FILE: design/rk2s_pkg.sv
// Package for the radix key to fixed-length string block.
// Holds widths, the configuration register indexes, the control structs and
// the clamping functions. Depends on nothing.
package rk2s_pkg;

  localparam int MAX_LEN   = 16;
  localparam int KEY_W     = 64;
  localparam int DIV_W     = KEY_W - 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int CHAR_W    = 8;
  localparam int RADIX_W   = 9;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = RADIX_W;

  localparam logic [CHAR_W-1:0]  BASE_CHAR_RST     = 8'd97;
  localparam logic [RADIX_W-1:0] ALPHABET_SIZE_RST = 9'd26;
  localparam logic [LEN_W-1:0]   PREFIX_LENGTH_RST = 5'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_CHAR     = 2'd0,
    CFG_ALPHABET_SIZE = 2'd1,
    CFG_PREFIX_LENGTH = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_OVF
  } state_e;

  // Divider control: load starts on a new dividend, start on the last quotient.
  typedef struct packed {
    logic load;
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
    logic quo_zero;
  } div_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  // Radix outside 2..256 is pulled to the nearest end.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_W'(2)) begin
      res = RADIX_W'(2);
    end else if (r > RADIX_W'(256)) begin
      res = RADIX_W'(256);
    end else begin
      res = r;
    end
    return res;
  endfunction

  // Length outside 1..MAX_LEN is pulled to the nearest end.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] res;
    if (l == '0) begin
      res = LEN_W'(1);
    end else if (l > LEN_W'(MAX_LEN)) begin
      res = LEN_W'(MAX_LEN);
    end else begin
      res = l;
    end
    return res;
  endfunction

endpackage

FILE: design/rk2s_if.sv
// Request channels of the radix key to fixed-length string block.
// One interface for incoming keys, one for outgoing characters.
// Depends on rk2s_pkg.
interface rk2s_key_if import rk2s_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key_value;

  modport source (output valid, output key_value, input ready);
  modport sink (input valid, input key_value, output ready);
endinterface

interface rk2s_chr_if import rk2s_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              overflow;
  logic              last;

  modport source (output valid, output character, output overflow, output last,
                  input ready);
  modport sink (input valid, input character, input overflow, input last,
                output ready);
endinterface

FILE: design/rk2s_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// The quotient stays in place so that the next division can start on it.
// Depends on rk2s_pkg.
module rk2s_div import rk2s_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_ctrl_t          ctrl_i,
  input  logic [DIV_W-1:0]   dividend_i,
  input  logic [RADIX_W-1:0] radix_i,
  output div_stat_t          stat_o,
  output logic [CHAR_W-1:0]  rem_o
);

  logic [DIV_W-1:0]     quo_q;
  logic [CHAR_W-1:0]    rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [RADIX_W-1:0]   trial;
  logic [RADIX_W-1:0]   diff;
  logic                 sub_ok;

  // Bring down the next dividend bit and try to subtract the radix.
  always_comb begin
    trial  = {rem_q, quo_q[DIV_W-1]};
    sub_ok = (trial >= radix_i);
    diff   = trial - radix_i;
  end

  // Control state of the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.load || ctrl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath: quotient bits shift in at the bottom as dividend bits leave the top.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (ctrl_i.start) begin
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], sub_ok};
      rem_q <= sub_ok ? diff[CHAR_W-1:0] : trial[CHAR_W-1:0];
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.quo_zero = (quo_q == '0);
  assign rem_o           = rem_q;

endmodule

FILE: design/rk2s_stack.sv
// Character stack built as a shift register of MAX_LEN entries.
// Digits arrive least significant first and leave most significant first.
// Depends on rk2s_pkg.
module rk2s_stack import rk2s_pkg::*; (
  input  logic              clk_i,
  input  stk_ctrl_t         ctrl_i,
  input  logic [CHAR_W-1:0] data_i,
  output logic [CHAR_W-1:0] top_o
);

  logic [CHAR_W-1:0] stk_q [MAX_LEN];

  // A push moves every entry one place down, a pop one place up.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      stk_q[0] <= data_i;
      for (int i = 1; i < MAX_LEN; i++) begin
        stk_q[i] <= stk_q[i-1];
      end
    end else if (ctrl_i.pop) begin
      for (int i = 0; i < MAX_LEN - 1; i++) begin
        stk_q[i] <= stk_q[i+1];
      end
    end
  end

  assign top_o = stk_q[0];

endmodule

FILE: design/radix_key_to_fixed_length_string.sv
// Radix key to fixed-length string: top level.
// Uses rk2s_pkg, rk2s_if, rk2s_div and rk2s_stack.
//
// A key arrives on key_in as a valid/ready request and is written as
// prefix_length characters of base alphabet_size, most significant first,
// each equal to base_char plus its digit. Characters leave on res_out, with
// last set on the final one. A negative key is taken and dropped without any
// result. A key that needs more digits than prefix_length gives a single
// result with overflow and last set and a character of zero.
// The block works on one key at a time: key_in.ready is high only while idle.
// Each digit costs one pass of the bit-serial divider, after which the
// character for its remainder is pushed onto the stack; all characters of a
// key are computed before its first character leaves. While the receiver
// holds res_out.ready low the current character holds and the block waits.
// After reset the registers hold base_char 97, alphabet_size 26 and
// prefix_length 9, and the block is idle.
// The configuration port writes one register per cycle with cfg_we_i.
module radix_key_to_fixed_length_string import rk2s_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rk2s_key_if.sink              key_in,
  rk2s_chr_if.source            res_out
);

  logic [CHAR_W-1:0]  base_char_q;
  logic [RADIX_W-1:0] alphabet_size_q;
  logic [LEN_W-1:0]   prefix_length_q;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;

  logic [RADIX_W-1:0] radix;
  logic [LEN_W-1:0]   len;
  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [CHAR_W-1:0]  div_rem;
  stk_ctrl_t          stk_ctrl;
  logic [CHAR_W-1:0]  stk_top;
  logic [CHAR_W-1:0]  new_char;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_char_q     <= BASE_CHAR_RST;
      alphabet_size_q <= ALPHABET_SIZE_RST;
      prefix_length_q <= PREFIX_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BASE_CHAR:     base_char_q     <= cfg_data_i[CHAR_W-1:0];
        CFG_ALPHABET_SIZE: alphabet_size_q <= cfg_data_i[RADIX_W-1:0];
        CFG_PREFIX_LENGTH: prefix_length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign radix    = clamp_radix(alphabet_size_q);
  assign len      = clamp_len(prefix_length_q);
  assign new_char = base_char_q + div_rem;

  // State register and digit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_d           = state_q;
    cnt_d             = cnt_q;
    div_ctrl          = '0;
    stk_ctrl          = '0;
    key_in.ready      = 1'b0;
    res_out.valid     = 1'b0;
    res_out.character = stk_top;
    res_out.overflow  = 1'b0;
    res_out.last      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        key_in.ready = 1'b1;
        if (key_in.valid && !key_in.key_value[KEY_W-1]) begin
          div_ctrl.load = 1'b1;
          cnt_d         = '0;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          stk_ctrl.push = 1'b1;
          if (cnt_q + LEN_W'(1) == len) begin
            cnt_d   = len;
            state_d = div_stat.quo_zero ? ST_EMIT : ST_OVF;
          end else begin
            cnt_d          = cnt_q + LEN_W'(1);
            div_ctrl.start = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        res_out.valid = 1'b1;
        res_out.last  = (cnt_q == LEN_W'(1));
        if (res_out.ready) begin
          stk_ctrl.pop = 1'b1;
          cnt_d        = cnt_q - LEN_W'(1);
          if (cnt_q == LEN_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_OVF: begin
        res_out.valid     = 1'b1;
        res_out.character = '0;
        res_out.overflow  = 1'b1;
        res_out.last      = 1'b1;
        if (res_out.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  rk2s_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (key_in.key_value[DIV_W-1:0]),
    .radix_i    (radix),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  rk2s_stack u_stack (
    .clk_i  (clk_i),
    .ctrl_i (stk_ctrl),
    .data_i (new_char),
    .top_o  (stk_top)
  );

endmodule
